// File: hw/rtl/arrt_pkg.sv
package arrt_pkg;

    localparam int ADDR_W = 31;
    localparam int DATA_W = 32;
    localparam int SLOT_W = 4;

    localparam logic ACT_INSERT    = 1'b0;
    localparam logic ACT_TRANSLATE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_COLLIDE = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISS    = 2'd3
    } arrt_status_t;

    // item as it walks down the chain of cells
    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] new_lim;   // addr + length, exact in 32 bits
        logic [DATA_W-1:0] data;
    } arrt_item_t;

    // what the cells passed so far have found
    typedef struct packed {
        logic              collide;
        logic              same_hit;
        logic              free_hit;
        logic              hit;
        logic [DATA_W-1:0] xlat;
    } arrt_flags_t;

    // region write broadcast from the tail to every cell
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] base;
        logic [DATA_W-1:0] lim;       // base + length
        logic [DATA_W-1:0] delta;     // data base - base, modulo 2^32
    } arrt_wr_t;

endpackage

// File: hw/rtl/arrt_cell.sv
module arrt_cell
    import arrt_pkg::*;
#(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  arrt_wr_t         wr,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic             in_valid,
    input  arrt_item_t       in_item,
    input  arrt_flags_t      in_flags,
    input  logic [IDX_W-1:0] in_same_idx,
    input  logic [IDX_W-1:0] in_free_idx,
    input  logic [IDX_W-1:0] in_hit_idx,
    output logic             out_valid,
    output arrt_item_t       out_item,
    output arrt_flags_t      out_flags,
    output logic [IDX_W-1:0] out_same_idx,
    output logic [IDX_W-1:0] out_free_idx,
    output logic [IDX_W-1:0] out_hit_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    // region held by this cell
    logic              ent_valid_reg;
    logic [ADDR_W-1:0] ent_base_reg;
    logic [DATA_W-1:0] ent_lim_reg;
    logic [DATA_W-1:0] ent_delta_reg;

    // pipeline stage toward the next cell
    logic              valid_reg,    valid_next;
    arrt_item_t        item_reg;
    arrt_flags_t       flags_reg,    flags_next;
    logic [IDX_W-1:0]  same_idx_reg, same_idx_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]  hit_idx_reg,  hit_idx_next;

    logic              base_above;
    logic              contains;
    logic              collide_here;
    logic              same_here;
    logic              free_here;
    logic [DATA_W-1:0] xlat_here;

    always_comb begin
        base_above   = (ent_base_reg > in_item.addr) &&
                       ({1'b0, ent_base_reg} < in_item.new_lim);
        contains     = (ent_base_reg <= in_item.addr) &&
                       (ent_lim_reg > {1'b0, in_item.addr});
        collide_here = ent_valid_reg && (base_above || contains);
        same_here    = ent_valid_reg && (ent_base_reg == in_item.addr);
        free_here    = !ent_valid_reg;
        xlat_here    = ent_delta_reg + {1'b0, in_item.addr};

        flags_next    = in_flags;
        same_idx_next = in_same_idx;
        free_idx_next = in_free_idx;
        hit_idx_next  = in_hit_idx;
        valid_next    = in_valid;

        flags_next.collide = in_flags.collide || collide_here;
        // keep the lowest slot of each kind
        if (!in_flags.same_hit && same_here) begin
            flags_next.same_hit = 1'b1;
            same_idx_next       = MY_IDX;
        end
        if (!in_flags.free_hit && free_here) begin
            flags_next.free_hit = 1'b1;
            free_idx_next       = MY_IDX;
        end
        if (!in_flags.hit && ent_valid_reg && contains) begin
            flags_next.hit  = 1'b1;
            flags_next.xlat = xlat_here;
            hit_idx_next    = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= 1'b0;
        end else if (wr.en && wr_idx == MY_IDX) begin
            ent_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && wr_idx == MY_IDX) begin
            ent_base_reg  <= wr.base;
            ent_lim_reg   <= wr.lim;
            ent_delta_reg <= wr.delta;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg     <= in_item;
            flags_reg    <= flags_next;
            same_idx_reg <= same_idx_next;
            free_idx_reg <= free_idx_next;
            hit_idx_reg  <= hit_idx_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_item     = item_reg;
    assign out_flags    = flags_reg;
    assign out_same_idx = same_idx_reg;
    assign out_free_idx = free_idx_reg;
    assign out_hit_idx  = hit_idx_reg;

endmodule

// File: hw/rtl/arrt_tail.sv
module arrt_tail
    import arrt_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  logic              fire,
    input  arrt_item_t        item,
    input  arrt_flags_t       flags,
    input  logic [IDX_W-1:0]  same_idx,
    input  logic [IDX_W-1:0]  free_idx,
    input  logic [IDX_W-1:0]  hit_idx,
    output arrt_status_t      status,
    output logic [DATA_W-1:0] translated,
    output logic [SLOT_W-1:0] slot,
    output arrt_wr_t          wr,
    output logic [IDX_W-1:0]  wr_idx
);

    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [IDX_W-1:0]        slot_idx;
    logic                    do_write;

    always_comb begin
        status     = ST_OK;
        translated = '0;
        slot_idx   = '0;
        do_write   = 1'b0;
        wr_idx     = '0;

        unique case (item.action)
            ACT_INSERT: begin
                priority if (flags.collide) begin
                    status = ST_COLLIDE;
                end else if (item.addr == '0) begin
                    status = ST_OK;
                end else if (flags.same_hit) begin
                    do_write = 1'b1;
                    wr_idx   = same_idx;
                    slot_idx = same_idx;
                end else if (flags.free_hit) begin
                    do_write = 1'b1;
                    wr_idx   = free_idx;
                    slot_idx = free_idx;
                end else begin
                    status = ST_FULL;
                end
            end
            ACT_TRANSLATE: begin
                if (flags.hit) begin
                    translated = flags.xlat;
                    slot_idx   = hit_idx;
                end else begin
                    status = ST_MISS;
                end
            end
            default: begin
                status = ST_MISS;
            end
        endcase

        slot_ext = {{SLOT_W{1'b0}}, slot_idx};
        slot     = slot_ext[SLOT_W-1:0];

        wr.en    = fire && do_write;
        wr.base  = item.addr;
        wr.lim   = item.new_lim;
        wr.delta = item.data - {1'b0, item.addr};
    end

endmodule

// File: hw/rtl/address_range_region_table_core.sv
// Region table for address translation. Insert items (action 0) add a region
// of base address and length with a backing data base, after an overlap check
// against every stored region; translate items (action 1) return data base
// plus offset of the region that holds the address, or a miss. One region
// sits in each cell of a chain of MAX_REGIONS cells, and an item walks the
// chain one cell per clock while the chain is not held, picking up overlap,
// same-base, free-slot and hit information on the way; the tail then decides and
// writes the chosen cell. An insert at base zero is checked but never stored.
// One item is in flight at a time: the next item is accepted only after the last
// has passed every cell and its result is written to the output register.
// A waiting result does not block acceptance of the next item.
module address_range_region_table_core
    import arrt_pkg::*;
#(
    parameter int MAX_REGIONS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [ADDR_W-1:0] s_address,
    input  logic [ADDR_W-1:0] s_length,
    input  logic [DATA_W-1:0] s_data_base,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [DATA_W-1:0] m_translated,
    output logic [SLOT_W-1:0] m_slot
);

    localparam int IDX_W = $clog2(MAX_REGIONS);

    logic              busy_reg,   busy_next;
    logic              in_valid_reg, in_valid_next;
    arrt_item_t        in_item_reg;
    logic              m_valid_reg, m_valid_next;
    arrt_status_t      m_status_reg;
    logic [DATA_W-1:0] m_translated_reg;
    logic [SLOT_W-1:0] m_slot_reg;

    logic              accept;
    logic              adv;
    logic              fire;

    logic              valid_bus    [MAX_REGIONS+1];
    arrt_item_t        item_bus     [MAX_REGIONS+1];
    arrt_flags_t       flags_bus    [MAX_REGIONS+1];
    logic [IDX_W-1:0]  same_idx_bus [MAX_REGIONS+1];
    logic [IDX_W-1:0]  free_idx_bus [MAX_REGIONS+1];
    logic [IDX_W-1:0]  hit_idx_bus  [MAX_REGIONS+1];

    arrt_wr_t          wr;
    logic [IDX_W-1:0]  wr_idx;
    arrt_status_t      tail_status;
    logic [DATA_W-1:0] tail_translated;
    logic [SLOT_W-1:0] tail_slot;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;

    // hold the whole chain while a finished item cannot enter the output register
    assign adv  = !(valid_bus[MAX_REGIONS] && m_valid_reg && !m_ready);
    assign fire = valid_bus[MAX_REGIONS] && adv;

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (fire) begin
            busy_next = 1'b0;
        end

        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_item_reg.action  <= s_action;
            in_item_reg.addr    <= s_address;
            in_item_reg.new_lim <= {1'b0, s_address} + {1'b0, s_length};
            in_item_reg.data    <= s_data_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_status_reg     <= tail_status;
            m_translated_reg <= tail_translated;
            m_slot_reg       <= tail_slot;
        end
    end

    assign valid_bus[0]    = in_valid_reg;
    assign item_bus[0]     = in_item_reg;
    assign flags_bus[0]    = '0;
    assign same_idx_bus[0] = '0;
    assign free_idx_bus[0] = '0;
    assign hit_idx_bus[0]  = '0;

    for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
        arrt_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .adv          (adv),
            .wr           (wr),
            .wr_idx       (wr_idx),
            .in_valid     (valid_bus[i]),
            .in_item      (item_bus[i]),
            .in_flags     (flags_bus[i]),
            .in_same_idx  (same_idx_bus[i]),
            .in_free_idx  (free_idx_bus[i]),
            .in_hit_idx   (hit_idx_bus[i]),
            .out_valid    (valid_bus[i+1]),
            .out_item     (item_bus[i+1]),
            .out_flags    (flags_bus[i+1]),
            .out_same_idx (same_idx_bus[i+1]),
            .out_free_idx (free_idx_bus[i+1]),
            .out_hit_idx  (hit_idx_bus[i+1])
        );
    end

    arrt_tail #(
        .IDX_W (IDX_W)
    ) u_tail (
        .fire       (fire),
        .item       (item_bus[MAX_REGIONS]),
        .flags      (flags_bus[MAX_REGIONS]),
        .same_idx   (same_idx_bus[MAX_REGIONS]),
        .free_idx   (free_idx_bus[MAX_REGIONS]),
        .hit_idx    (hit_idx_bus[MAX_REGIONS]),
        .status     (tail_status),
        .translated (tail_translated),
        .slot       (tail_slot),
        .wr         (wr),
        .wr_idx     (wr_idx)
    );

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_translated = m_translated_reg;
    assign m_slot       = m_slot_reg;

endmodule

// File: sim/arrt_region_sb_pkg.sv
package arrt_region_sb_pkg;
    import arrt_pkg::*;

    localparam int TABLE_DEPTH = 16;

    typedef struct packed {
        arrt_status_t      status;
        logic [DATA_W-1:0] translated;
        logic [SLOT_W-1:0] slot;
    } region_result_t;

    class region_scoreboard;
        logic [ADDR_W-1:0] base [TABLE_DEPTH];
        logic [ADDR_W-1:0] region_len [TABLE_DEPTH];
        logic [DATA_W-1:0] backing [TABLE_DEPTH];
        bit                live [TABLE_DEPTH];
        region_result_t    pending [$];
        int                errors;

        function new();
            errors = 0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        function region_result_t insert_region(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] l,
                                               logic [DATA_W-1:0] d);
            logic [DATA_W-1:0] lim;
            logic [DATA_W-1:0] stored_lim;
            int                same_slot;
            int                free_slot;
            region_result_t    r;
            r.status = ST_OK;
            r.translated = '0;
            r.slot = '0;
            same_slot = -1;
            free_slot = -1;
            // sums of two 31-bit values are exact in 32 bits
            lim = DATA_W'(a) + DATA_W'(l);
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (live[i]) begin
                    stored_lim = DATA_W'(base[i]) + DATA_W'(region_len[i]);
                    if ((DATA_W'(base[i]) > DATA_W'(a) && DATA_W'(base[i]) < lim) ||
                        (base[i] <= a && stored_lim > DATA_W'(a))) begin
                        r.status = ST_COLLIDE;
                        return r;
                    end
                end
            end
            // base zero passes the check but is never stored
            if (a == '0) return r;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (live[i]) begin
                    if (base[i] == a && same_slot < 0) same_slot = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (same_slot < 0) begin
                if (free_slot < 0) begin
                    r.status = ST_FULL;
                    return r;
                end
                same_slot = free_slot;
                live[same_slot] = 1'b1;
            end
            base[same_slot] = a;
            region_len[same_slot] = l;
            backing[same_slot] = d;
            r.slot = SLOT_W'(same_slot);
            return r;
        endfunction

        function region_result_t translate_addr(logic [ADDR_W-1:0] a);
            region_result_t r;
            r.status = ST_MISS;
            r.translated = '0;
            r.slot = '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (live[i] && base[i] <= a &&
                    DATA_W'(a) < DATA_W'(base[i]) + DATA_W'(region_len[i])) begin
                    r.status = ST_OK;
                    r.translated = backing[i] + (DATA_W'(a) - DATA_W'(base[i]));
                    r.slot = SLOT_W'(i);
                    return r;
                end
            end
            return r;
        endfunction

        function void note_item(logic act, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] l,
                                logic [DATA_W-1:0] d);
            region_result_t r;
            if (act == ACT_INSERT) r = insert_region(a, l, d);
            else r = translate_addr(a);
            pending = {pending, r};
        endfunction

        function void check_result(longint unsigned now_ns, logic [1:0] status,
                                   logic [DATA_W-1:0] translated, logic [SLOT_W-1:0] slot);
            region_result_t exp;
            if (pending.size() == 0) begin
                $display("@%0d ns: result with nothing expected: status %0d translated %h slot %0d",
                         now_ns, status, translated, slot);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (status !== exp.status) begin
                $display("@%0d ns: status expected %0d (%s) got %0d",
                         now_ns, exp.status, exp.status.name(), status);
                errors++;
            end
            if (translated !== exp.translated) begin
                $display("@%0d ns: translated expected %h got %h",
                         now_ns, exp.translated, translated);
                errors++;
            end
            if (slot !== exp.slot) begin
                $display("@%0d ns: slot expected %0d got %0d", now_ns, exp.slot, slot);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: sim/address_range_region_table_core_test.sv
module address_range_region_table_core_test;
    import arrt_pkg::*;
    import arrt_region_sb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1080;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_CYCLES  = 300;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_action = ACT_INSERT;
    logic [ADDR_W-1:0] s_address = '0;
    logic [ADDR_W-1:0] s_length = '0;
    logic [DATA_W-1:0] s_data_base = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_status;
    logic [DATA_W-1:0] m_translated;
    logic [SLOT_W-1:0] m_slot;

    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;

    region_scoreboard sb;

    address_range_region_table_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_address   (s_address),
        .s_length    (s_length),
        .s_data_base (s_data_base),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_translated(m_translated),
        .m_slot      (m_slot)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_item(s_action, s_address, s_length, s_data_base);
        if (aresetn && m_valid && m_ready)
            sb.check_result($time, m_status, m_translated, m_slot);
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_item(input logic act, input logic [ADDR_W-1:0] a,
                             input logic [ADDR_W-1:0] l, input logic [DATA_W-1:0] d);
        s_valid <= 1'b1;
        s_action <= act;
        s_address <= a;
        s_length <= l;
        s_data_base <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // mostly short lengths, now and then any 31-bit value
    function automatic logic [ADDR_W-1:0] rand_len();
        int k;
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 12);
        if (k >= 31) return ADDR_W'($urandom);
        return ADDR_W'($urandom & ((32'd1 << k) - 1));
    endfunction

    // mode 0: any live slot, 1: nonzero length, 2: zero length preferred
    function automatic int pick_live(input int mode);
        int q[$];
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (sb.live[i] && (mode != 1 || sb.region_len[i] != '0) &&
                (mode != 2 || sb.region_len[i] == '0))
                q = {q, i};
        end
        if (q.size() == 0) return (mode == 2) ? pick_live(0) : -1;
        return q[$urandom_range(0, q.size() - 1)];
    endfunction

    task automatic next_item(output logic act, output logic [ADDR_W-1:0] a,
                             output logic [ADDR_W-1:0] l, output logic [DATA_W-1:0] d);
        int                sel;
        int                i;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] n;
        act = ACT_TRANSLATE;
        a = ADDR_W'($urandom);
        l = ADDR_W'($urandom);
        d = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            i = pick_live(1);
            if (i >= 0) begin
                b = DATA_W'(sb.base[i]);
                n = DATA_W'(sb.region_len[i]);
                case ($urandom_range(0, 2))
                    0: a = ADDR_W'(b);
                    1: a = ADDR_W'(b + n - 1);
                    default: a = ADDR_W'(b + ($urandom % n));
                endcase
            end
        end else if (sel < 45) begin
            i = pick_live(0);
            if (i >= 0) begin
                b = DATA_W'(sb.base[i]);
                n = DATA_W'(sb.region_len[i]);
                case ($urandom_range(0, 2))
                    0: a = ADDR_W'(b - 1);
                    1: a = ADDR_W'(b + n);
                    default: ;
                endcase
            end
        end else if (sel < 65) begin
            act = ACT_INSERT;
            a = $urandom_range(0, 1) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(1, 32'hFFFFF));
            l = rand_len();
        end else if (sel < 80) begin
            // land on or next to the edges of a stored region
            act = ACT_INSERT;
            l = rand_len();
            i = pick_live(0);
            if (i >= 0) begin
                b = DATA_W'(sb.base[i]);
                n = DATA_W'(sb.region_len[i]);
                case ($urandom_range(0, 4))
                    0: a = ADDR_W'(b + n);
                    1: a = ADDR_W'(b + n - 1);
                    2: a = ADDR_W'(b - DATA_W'(l));
                    3: a = ADDR_W'(b - DATA_W'(l) + 1);
                    default: a = ADDR_W'(b + ($urandom % (n + 1)));
                endcase
            end
        end else if (sel < 90) begin
            act = ACT_INSERT;
            l = $urandom_range(0, 1) ? '0 : rand_len();
            i = pick_live(2);
            if (i >= 0) a = sb.base[i];
        end else begin
            act = ACT_INSERT;
            a = '0;
            l = rand_len();
        end
    endtask

    initial begin
        logic              act;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] l;
        logic [DATA_W-1:0] d;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table, base zero, extremes of the address space
        send_item(ACT_TRANSLATE, 31'h0, 31'h0, 32'h0);
        send_item(ACT_INSERT, 31'h0, 31'h7FFFFFFF, 32'h0);
        send_item(ACT_INSERT, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF);
        send_item(ACT_TRANSLATE, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF);
        send_item(ACT_INSERT, 31'h7FFFFFFE, 31'h1, 32'h0);
        send_item(ACT_INSERT, 31'h7FFFFFFD, 31'h2, 32'hA5A5A5A5);
        // zero-length region, then overwrite at the same base
        send_item(ACT_INSERT, 31'h100, 31'h0, 32'h12345678);
        send_item(ACT_TRANSLATE, 31'h100, 31'h0, 32'h0);
        send_item(ACT_INSERT, 31'h100, 31'h10, 32'h80000000);
        send_item(ACT_TRANSLATE, 31'h10F, 31'h0, 32'h0);
        send_item(ACT_TRANSLATE, 31'h110, 31'h0, 32'h0);
        send_item(ACT_INSERT, 31'hF0, 31'h10, 32'h1);
        send_item(ACT_INSERT, 31'hF0, 31'h11, 32'h2);
        send_item(ACT_INSERT, 31'h80, 31'h100, 32'h3);
        send_item(ACT_INSERT, 31'h0, 31'h200, 32'h4);
        send_item(ACT_INSERT, 31'h10F, 31'h5, 32'h5);
        // data base plus offset wraps past 32 bits
        send_item(ACT_INSERT, 31'h1000, 31'h1000, 32'hFFFFFF00);
        send_item(ACT_TRANSLATE, 31'h1FFF, 31'h0, 32'h0);
        send_item(ACT_TRANSLATE, 31'h1000, 31'h0, 32'h0);
        send_item(ACT_INSERT, 31'h300, 31'h0, 32'h0);
        send_item(ACT_INSERT, 31'h2F0, 31'h20, 32'h0);
        send_item(ACT_INSERT, 31'h300, 31'h0, 32'h55);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            gaps_on = (k < RANDOM_ITEMS - QUIET_TAIL) && ((k / 90) % 4 != 3);
            // stall the result side long enough for the input to back up
            if (k == 250) hold_req = 1'b1;
            next_item(act, a, l, d);
            if (gaps_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 17));
            send_item(act, a, l, d);
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (2 * TABLE_DEPTH + 8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(3_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
